// ===== src/gait_joint_trajectory_defines.svh =====
// Assertion helpers shared by the RTL of the gait joint trajectory block.
// Each check is disabled while reset is high.
`ifndef GAIT_JOINT_TRAJECTORY_DEFINES_SVH
`define GAIT_JOINT_TRAJECTORY_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define GJT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define GJT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define GJT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define GJT_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/gjt_pkg.sv =====
`timescale 1ns / 1ps

package gjt_pkg;

   // Leg count and field widths.
   localparam int LEGS       = 4;
   localparam int LEG_W      = 2;
   localparam int PHASE_W    = 16;
   localparam int PHASE_IN_W = 15;
   localparam int INC_W      = 15;
   localparam int AMP_W      = 8;
   localparam int BRK_W      = 7;
   localparam int BRKS_W     = 3 * BRK_W;
   localparam int ANGLE_W    = 15;

   // Word layouts on the streaming ports.
   localparam int REQ_FIELDS_W = LEG_W + PHASE_IN_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = LEG_W + 3 * ANGLE_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = BRKS_W;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_INC  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_ALPHA  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_BETA   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_GAMMA  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STANCE_BRK = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CORR_BRK   = 3'd6;

   localparam logic [INC_W-1:0]  PHASE_INC_RESET  = 15'd256;
   localparam logic [BRKS_W-1:0] STANCE_BRK_RESET = 21'd1648050;
   localparam logic [BRKS_W-1:0] CORR_BRK_RESET   = 21'd822400;

   // Item kinds.
   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_LOAD    = 1'b1;

   // Gait constants.
   localparam int FULL_CYCLE = 25600;
   localparam int CORR_AMP   = 40;
   localparam int SHIFT_NEAR = 25;
   localparam int SHIFT_FAR  = 75;
   localparam int ANGLE_MAX  = 16383;
   localparam int ANGLE_MIN  = -16384;

   // Slope datapath widths.
   localparam int SPAN_W      = BRK_W + 1;
   localparam int SPAN_ABS_W  = BRK_W;
   localparam int BRK_SHIFT   = 8;
   localparam int X_W         = PHASE_W + 2;
   localparam int XABS_W      = X_W - 1;
   localparam int DIVIDEND_W  = XABS_W + AMP_W;
   localparam int DIVISOR_W   = SPAN_ABS_W + 2;
   localparam int DIV_BITS    = 4;
   localparam int DIV_STEPS   = (DIVIDEND_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIV_PAD_W   = DIV_STEPS * DIV_BITS;
   localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
   localparam int ACC_W       = DIVIDEND_W + 3;

   // Term sequencing.
   localparam int NUM_TERMS  = 13;
   localparam int TERM_IDX_W = $clog2(NUM_TERMS);
   localparam logic [TERM_IDX_W-1:0] TERM_LAST = TERM_IDX_W'(NUM_TERMS - 1);

   localparam logic [SPAN_W-1:0] BRK_NEAR = SPAN_W'(SHIFT_NEAR);
   localparam logic [SPAN_W-1:0] BRK_FAR  = SPAN_W'(SHIFT_FAR);
   localparam logic [AMP_W-1:0]  AMP_CORR = AMP_W'(CORR_AMP);

   localparam logic signed [ACC_W-1:0] ACC_ANGLE_MAX = ACC_W'(ANGLE_MAX);
   localparam logic signed [ACC_W-1:0] ACC_ANGLE_MIN = ACC_W'(ANGLE_MIN);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DIV,
      ST_ACC,
      ST_SAT
   } state_type;

   typedef enum logic [1:0] {
      TGT_ALPHA,
      TGT_BETA,
      TGT_GAMMA
   } target_type;

   // One slope term: breakpoint offsets are two's complement whole percent.
   typedef struct packed {
      logic [SPAN_W-1:0] x_base;
      logic [SPAN_W-1:0] span;
      logic [SPAN_W-1:0] win_lo;
      logic [SPAN_W-1:0] win_hi;
      logic [AMP_W-1:0]  amp;
      logic              dbl;
      logic              neg;
      logic              flip;
      logic              corr;
      logic              windowed;
      target_type        tgt;
   } term_type;

   // Divider request and response.
   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   // Scales a signed percent breakpoint to phase units.
   function automatic logic signed [X_W-1:0] brk_scaled(input logic [SPAN_W-1:0] v);
      brk_scaled = $signed({{(X_W - SPAN_W - BRK_SHIFT){v[SPAN_W-1]}}, v,
                            {BRK_SHIFT{1'b0}}});
   endfunction

   // Clamps an accumulated angle to the output field.
   function automatic logic [ANGLE_W-1:0] sat_angle(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] c;
      c = v;
      if (v > ACC_ANGLE_MAX) begin
         c = ACC_ANGLE_MAX;
      end else if (v < ACC_ANGLE_MIN) begin
         c = ACC_ANGLE_MIN;
      end
      sat_angle = c[ANGLE_W-1:0];
   endfunction

   // Describes slope term idx of the angle sums. Each triangle contributes a
   // term at its start and a doubled term of opposite sign at its middle.
   function automatic term_type term_lookup(
      input logic [TERM_IDX_W-1:0] idx,
      input logic [BRK_W-1:0]      e,
      input logic [BRK_W-1:0]      f,
      input logic [BRK_W-1:0]      g,
      input logic [BRK_W-1:0]      b,
      input logic [BRK_W-1:0]      c,
      input logic [BRK_W-1:0]      d,
      input logic [AMP_W-1:0]      amp_a,
      input logic [AMP_W-1:0]      amp_b,
      input logic [AMP_W-1:0]      amp_g
   );
      logic [SPAN_W-1:0] se, sf, sg, sb, sc, sd;
      term_type t;
      se = {1'b0, e};
      sf = {1'b0, f};
      sg = {1'b0, g};
      sb = {1'b0, b};
      sc = {1'b0, c};
      sd = {1'b0, d};
      t = '0;
      unique case (idx)
         4'd0: begin
            t.span  = se;
            t.amp   = amp_a;
         end
         4'd1: begin
            t.x_base = se;
            t.span   = se;
            t.amp    = amp_a;
            t.neg    = 1'b1;
         end
         4'd2: begin
            t.x_base = se;
            t.span   = sg - se;
            t.amp    = amp_a;
            t.neg    = 1'b1;
         end
         4'd3: begin
            t.x_base   = se;
            t.span     = sf - se;
            t.amp      = amp_b;
            t.windowed = 1'b1;
            t.win_lo   = se;
            t.win_hi   = sg;
            t.tgt      = TGT_BETA;
         end
         4'd4: begin
            t.x_base   = sf;
            t.span     = sf - se;
            t.amp      = amp_b;
            t.dbl      = 1'b1;
            t.neg      = 1'b1;
            t.windowed = 1'b1;
            t.win_lo   = se;
            t.win_hi   = sg;
            t.tgt      = TGT_BETA;
         end
         4'd5: begin
            t.x_base   = se - BRK_NEAR;
            t.span     = sf - se;
            t.amp      = AMP_CORR;
            t.flip     = 1'b1;
            t.corr     = 1'b1;
            t.windowed = 1'b1;
            t.win_lo   = se - BRK_NEAR;
            t.win_hi   = sg - BRK_NEAR;
         end
         4'd6: begin
            t.x_base   = sf - BRK_NEAR;
            t.span     = sf - se;
            t.amp      = AMP_CORR;
            t.dbl      = 1'b1;
            t.neg      = 1'b1;
            t.flip     = 1'b1;
            t.corr     = 1'b1;
            t.windowed = 1'b1;
            t.win_lo   = se - BRK_NEAR;
            t.win_hi   = sg - BRK_NEAR;
         end
         4'd7: begin
            t.x_base   = se - BRK_FAR;
            t.span     = sf - se;
            t.amp      = AMP_CORR;
            t.neg      = 1'b1;
            t.flip     = 1'b1;
            t.corr     = 1'b1;
            t.windowed = 1'b1;
            t.win_lo   = se - BRK_FAR;
            t.win_hi   = sg - BRK_FAR;
         end
         4'd8: begin
            t.x_base   = sf - BRK_FAR;
            t.span     = sf - se;
            t.amp      = AMP_CORR;
            t.dbl      = 1'b1;
            t.flip     = 1'b1;
            t.corr     = 1'b1;
            t.windowed = 1'b1;
            t.win_lo   = se - BRK_FAR;
            t.win_hi   = sg - BRK_FAR;
         end
         4'd9: begin
            t.x_base   = sb;
            t.span     = sc - sb;
            t.amp      = AMP_CORR;
            t.neg      = 1'b1;
            t.corr     = 1'b1;
            t.windowed = 1'b1;
            t.win_lo   = sb;
            t.win_hi   = sd;
            t.tgt      = TGT_BETA;
         end
         4'd10: begin
            t.x_base   = sc;
            t.span     = sc - sb;
            t.amp      = AMP_CORR;
            t.dbl      = 1'b1;
            t.corr     = 1'b1;
            t.windowed = 1'b1;
            t.win_lo   = sb;
            t.win_hi   = sd;
            t.tgt      = TGT_BETA;
         end
         4'd11: begin
            t.x_base   = sb;
            t.span     = sc - sb;
            t.amp      = amp_g;
            t.corr     = 1'b1;
            t.windowed = 1'b1;
            t.win_lo   = sb;
            t.win_hi   = sd;
            t.tgt      = TGT_GAMMA;
         end
         4'd12: begin
            t.x_base   = sc;
            t.span     = sc - sb;
            t.amp      = amp_g;
            t.dbl      = 1'b1;
            t.neg      = 1'b1;
            t.corr     = 1'b1;
            t.windowed = 1'b1;
            t.win_lo   = sb;
            t.win_hi   = sd;
            t.tgt      = TGT_GAMMA;
         end
         default: begin
            t = '0;
         end
      endcase
      term_lookup = t;
   endfunction

endpackage

// ===== src/gjt_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider that retires DIV_BITS quotient bits per cycle.
module gjt_divider (
   input  logic                clock,
   input  logic                reset,
   input  gjt_pkg::div_req_type div_req,
   output gjt_pkg::div_rsp_type div_rsp
);
   import gjt_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_PAD_W-1:0]  quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;

   // Shift the dividend out at the top and the quotient in at the bottom.
   always_comb begin
      logic [DIVISOR_W:0]   trial;
      logic [DIV_PAD_W-1:0] q;
      logic [DIVISOR_W-1:0] r;
      trial   = '0;
      q       = quo_ff;
      r       = rem_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = DIV_PAD_W'(div_req.dividend);
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         for (int k = 0; k < DIV_BITS; k++) begin
            trial = {r, q[DIV_PAD_W-1]};
            q     = {q[DIV_PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, den_ff}) begin
               trial = trial - {1'b0, den_ff};
               q[0]  = 1'b1;
            end
            r = trial[DIVISOR_W-1:0];
         end
         quo_in = q;
         rem_in = r;
         if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[DIVIDEND_W-1:0];

endmodule

// ===== src/gait_joint_trajectory.sv =====
`timescale 1ns / 1ps
`include "gait_joint_trajectory_defines.svh"
// Load word: taken with no response; the next word can be taken right after.
// Advance word: one response after its 13 slope terms, each skipped when empty
// or else sent through the shared multiply and 4-bit-per-cycle divider.
// One word in flight at a time.
// Reset clears all leg phases to zero and loads the register defaults.
module gait_joint_trajectory (
   input  logic                            clock,
   input  logic                            reset,
   // Request stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [gjt_pkg::REQ_DATA_W-1:0]  req_tdata,  // leg, phase_value
   input  logic                            req_tuser,  // op
   // Response stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [gjt_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // leg_out, hip, knee, third
   // Register writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gjt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gjt_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gjt_pkg::*;

   // Configuration registers.
   logic [INC_W-1:0]  phase_inc_ff;
   logic [AMP_W-1:0]  amp_alpha_ff;
   logic [AMP_W-1:0]  amp_beta_ff;
   logic [AMP_W-1:0]  amp_gamma_ff;
   logic              gravity_ff;
   logic [BRKS_W-1:0] stance_brk_ff;
   logic [BRKS_W-1:0] corr_brk_ff;

   // Sequencer and datapath registers.
   state_type               state_ff, state_in;
   logic [PHASE_W-1:0]      phase_ff [LEGS];
   logic [PHASE_W-1:0]      phase_in [LEGS];
   logic [TERM_IDX_W-1:0]   term_ff, term_in;
   logic [LEG_W-1:0]        leg_ff, leg_in;
   logic [PHASE_W-1:0]      n_ff, n_in;
   logic [XABS_W-1:0]       x_abs_ff, x_abs_in;
   logic [AMP_W-1:0]        amp_ff, amp_in;
   logic [SPAN_ABS_W-1:0]   span_abs_ff, span_abs_in;
   logic                    neg_ff, neg_in;
   logic                    dbl_ff, dbl_in;
   target_type              tgt_ff, tgt_in;
   logic signed [ACC_W-1:0] alpha_ff, alpha_in;
   logic signed [ACC_W-1:0] beta_ff, beta_in;
   logic signed [ACC_W-1:0] gamma_ff, gamma_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // Request fields and control.
   logic                    req_op;
   logic [LEG_W-1:0]        req_leg;
   logic [PHASE_IN_W-1:0]   req_phase;
   logic                    req_accept;
   logic                    leg_ok;
   logic                    start_advance;
   logic                    rsp_load;

   // Current slope term.
   term_type                desc;
   logic signed [X_W-1:0]   n_ext;
   logic signed [X_W-1:0]   x_val;
   logic [SPAN_W-1:0]       span_neg;
   logic                    flip_leg;
   logic                    term_active;

   // Shared multiply and divide.
   logic [DIVIDEND_W-1:0]   product;
   logic [ACC_W-1:0]        term_mag;
   logic signed [ACC_W-1:0] term_val;
   logic                    div_start;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   assign req_op    = req_tuser;
   assign req_leg   = req_tdata[LEG_W-1:0];
   assign req_phase = req_tdata[LEG_W +: PHASE_IN_W];

   assign req_accept    = req_tvalid && req_tready;
   assign leg_ok        = int'(req_leg) < LEGS;
   assign start_advance = req_accept && (req_op == OP_ADVANCE) && leg_ok;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Term decode and activity test.
   always_comb begin
      desc = term_lookup(term_ff,
                         stance_brk_ff[BRK_W-1:0],
                         stance_brk_ff[2*BRK_W-1:BRK_W],
                         stance_brk_ff[3*BRK_W-1:2*BRK_W],
                         corr_brk_ff[BRK_W-1:0],
                         corr_brk_ff[2*BRK_W-1:BRK_W],
                         corr_brk_ff[3*BRK_W-1:2*BRK_W],
                         amp_alpha_ff, amp_beta_ff, amp_gamma_ff);
      n_ext    = $signed({{(X_W - PHASE_W){1'b0}}, n_ff});
      x_val    = n_ext - brk_scaled(desc.x_base);
      span_neg = -desc.span;
      flip_leg = !(leg_ff == LEG_W'(0) || leg_ff == LEG_W'(3));
      term_active = (!desc.corr || gravity_ff)
                 && (!desc.windowed || ((n_ext >= brk_scaled(desc.win_lo))
                                     && (n_ext <= brk_scaled(desc.win_hi))))
                 && (desc.span != '0)
                 && (x_val > $signed(X_W'(0)));
   end

   // Multiply feeding the divider, and the signed weighted quotient.
   always_comb begin
      product  = {{AMP_W{1'b0}}, x_abs_ff} * {{XABS_W{1'b0}}, amp_ff};
      div_req.start    = div_start;
      div_req.dividend = product + DIVIDEND_W'({span_abs_ff, 1'b0});
      div_req.divisor  = {span_abs_ff, 2'b00};
      term_mag = dbl_ff ? ACC_W'({div_rsp.quotient, 1'b0}) : ACC_W'(div_rsp.quotient);
      term_val = neg_ff ? -$signed(term_mag) : $signed(term_mag);
   end

   gjt_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_advance) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (term_active) begin
               state_in = ST_MUL;
            end else if (term_ff == TERM_LAST) begin
               state_in = ST_SAT;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = (term_ff == TERM_LAST) ? ST_SAT : ST_SETUP;
         end
         ST_SAT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_MUL:   div_start  = 1'b1;
         ST_SAT:   rsp_load   = !rsp_valid_ff || rsp_tready;
         default:  ;
      endcase
   end

   // Datapath next values.
   always_comb begin
      logic [PHASE_W-1:0] cur_phase;
      cur_phase   = phase_ff[req_leg];
      phase_in    = phase_ff;
      term_in     = term_ff;
      leg_in      = leg_ff;
      n_in        = n_ff;
      x_abs_in    = x_abs_ff;
      amp_in      = amp_ff;
      span_abs_in = span_abs_ff;
      neg_in      = neg_ff;
      dbl_in      = dbl_ff;
      tgt_in      = tgt_ff;
      alpha_in    = alpha_ff;
      beta_in     = beta_ff;
      gamma_in    = gamma_ff;

      // Phase update on an accepted word.
      if (req_accept && leg_ok) begin
         if (req_op == OP_LOAD) begin
            phase_in[req_leg] = {1'b0, req_phase};
         end else begin
            if (cur_phase >= PHASE_W'(FULL_CYCLE)) begin
               cur_phase = '0;
            end
            cur_phase         = cur_phase + {1'b0, phase_inc_ff};
            phase_in[req_leg] = cur_phase;
            n_in              = cur_phase;
            leg_in            = req_leg;
            term_in           = '0;
            alpha_in          = '0;
            beta_in           = '0;
            gamma_in          = '0;
         end
      end

      // Capture an active term, or step past an empty one.
      if (state_ff == ST_SETUP) begin
         if (term_active) begin
            x_abs_in    = x_val[XABS_W-1:0];
            amp_in      = desc.amp;
            span_abs_in = desc.span[SPAN_W-1] ? span_neg[SPAN_ABS_W-1:0]
                                              : desc.span[SPAN_ABS_W-1:0];
            neg_in      = desc.neg ^ desc.span[SPAN_W-1] ^ (desc.flip & flip_leg);
            dbl_in      = desc.dbl;
            tgt_in      = desc.tgt;
         end else if (term_ff != TERM_LAST) begin
            term_in = term_ff + 1'b1;
         end
      end

      // Fold the quotient into its angle.
      if (state_ff == ST_ACC) begin
         case (tgt_ff)
            TGT_ALPHA: alpha_in = alpha_ff + term_val;
            TGT_BETA:  beta_in  = beta_ff + term_val;
            TGT_GAMMA: gamma_in = gamma_ff + term_val;
            default:   ;
         endcase
         if (term_ff != TERM_LAST) begin
            term_in = term_ff + 1'b1;
         end
      end
   end

   // Response word register.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}},
                         sat_angle(gamma_ff), sat_angle(beta_ff),
                         sat_angle(alpha_ff), leg_ff};
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff  <= PHASE_INC_RESET;
         amp_alpha_ff  <= '0;
         amp_beta_ff   <= '0;
         amp_gamma_ff  <= '0;
         gravity_ff    <= 1'b0;
         stance_brk_ff <= STANCE_BRK_RESET;
         corr_brk_ff   <= CORR_BRK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PHASE_INC:  phase_inc_ff  <= csr_data[INC_W-1:0];
            CSR_AMP_ALPHA:  amp_alpha_ff  <= csr_data[AMP_W-1:0];
            CSR_AMP_BETA:   amp_beta_ff   <= csr_data[AMP_W-1:0];
            CSR_AMP_GAMMA:  amp_gamma_ff  <= csr_data[AMP_W-1:0];
            CSR_GRAVITY:    gravity_ff    <= csr_data[0];
            CSR_STANCE_BRK: stance_brk_ff <= csr_data;
            CSR_CORR_BRK:   corr_brk_ff   <= csr_data;
            default:        ;
         endcase
      end
   end

   // Control state and leg phases.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEGS; i++) begin
            phase_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      term_ff     <= term_in;
      leg_ff      <= leg_in;
      n_ff        <= n_in;
      x_abs_ff    <= x_abs_in;
      amp_ff      <= amp_in;
      span_abs_ff <= span_abs_in;
      neg_ff      <= neg_in;
      dbl_ff      <= dbl_in;
      tgt_ff      <= tgt_in;
      alpha_ff    <= alpha_in;
      beta_ff     <= beta_in;
      gamma_ff    <= gamma_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A divide never starts on an empty term.
   `GJT_ASSERT_IMP(a_mul_nonzero, clock, reset, state_ff == ST_MUL, (x_abs_ff != '0) && (span_abs_ff != '0), "divide started on an empty term")
   // Accumulation only follows a finished divide.
   `GJT_ASSERT_IMP(a_acc_after_done, clock, reset, state_ff == ST_ACC, $past(div_rsp.done), "accumulate without a finished quotient")
   // An advance starts the term sweep at its first term.
   `GJT_ASSERT_NXT(a_advance_start, clock, reset, start_advance, (state_ff == ST_SETUP) && (term_ff == '0), "advance did not restart the term sweep")
   // A response appears only out of the saturation step.
   `GJT_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_SAT, "response word raised outside saturation")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import gjt_pkg::*;

   // Index beyond the register map; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 160;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 158;
   localparam int PHASE_IN_MAX  = 32767;

   typedef struct {
      logic                  op;
      logic [LEG_W-1:0]      leg;
      logic [PHASE_IN_W-1:0] phase;
   } gait_cmd_type;

   typedef struct {
      logic [LEG_W-1:0]   leg;
      logic [ANGLE_W-1:0] hip;
      logic [ANGLE_W-1:0] knee;
      logic [ANGLE_W-1:0] third;
   } angle_set_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // Gait model: register copies and per-leg phase.
   logic [INC_W-1:0]   cfg_inc       = PHASE_INC_RESET;
   logic [AMP_W-1:0]   cfg_amp_hip   = '0;
   logic [AMP_W-1:0]   cfg_amp_knee  = '0;
   logic [AMP_W-1:0]   cfg_amp_third = '0;
   logic               cfg_gravity   = 1'b0;
   logic [BRKS_W-1:0]  cfg_stance    = STANCE_BRK_RESET;
   logic [BRKS_W-1:0]  cfg_corr      = CORR_BRK_RESET;
   logic [PHASE_W-1:0] gait_phase [LEGS] = '{default: '0};

   gait_cmd_type  pending_cmds[$];
   angle_set_type expected_angles[$];

   // Traffic shaping shared between the sequence and the bus processes.
   logic sender_bursty  = 1'b0;
   int   stall_max      = 0;
   logic hold_request   = 1'b0;
   logic req_taken      = 1'b0;
   int   burst_left     = 0;
   int   gap_left       = 0;
   int   hold_left      = 0;
   int   ready_run_left = 0;
   logic ready_level    = 1'b1;

   int error_count   = 0;
   int advances_seen = 0;
   int loads_seen    = 0;
   int angles_seen   = 0;
   int csr_writes    = 0;
   int settings_used = 0;
   int cycle_count   = 0;

   gait_joint_trajectory uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Rounded ramp value in 1/64 degree; halves round away from zero and the
   // sign follows the span.
   function automatic longint ramp_term(longint x, longint amp, longint span);
      longint den;
      longint q;
      if (span == 0 || x <= 0) return 0;
      den = (span < 0 ? -span : span) * 4;
      q = (x * amp + den / 2) / den;
      return (span < 0) ? -q : q;
   endfunction

   // Triangle that rises from s0, peaks at s1 and is cut off outside s0..stop.
   function automatic longint window_tri(longint n, longint s0, longint s1,
                                         longint stop, longint amp);
      if (n < s0 * 256 || n > stop * 256) return 0;
      return ramp_term(n - s0 * 256, amp, s1 - s0)
             - 2 * ramp_term(n - s1 * 256, amp, s1 - s0);
   endfunction

   function automatic logic [ANGLE_W-1:0] clamp_angle(longint v);
      longint c;
      c = v;
      if (c > ANGLE_MAX) c = ANGLE_MAX;
      if (c < ANGLE_MIN) c = ANGLE_MIN;
      return c[ANGLE_W-1:0];
   endfunction

   // Joint angles for one leg at phase n under the current registers.
   function automatic angle_set_type predict_angles(logic [LEG_W-1:0] leg, longint n);
      longint e, f, g, b, c, d, amp_hip, hip, knee, third, near_tri, far_tri;
      angle_set_type r;
      e = longint'(cfg_stance[0 +: BRK_W]);
      f = longint'(cfg_stance[BRK_W +: BRK_W]);
      g = longint'(cfg_stance[2 * BRK_W +: BRK_W]);
      b = longint'(cfg_corr[0 +: BRK_W]);
      c = longint'(cfg_corr[BRK_W +: BRK_W]);
      d = longint'(cfg_corr[2 * BRK_W +: BRK_W]);
      amp_hip = longint'(cfg_amp_hip);
      hip = ramp_term(n, amp_hip, e) - ramp_term(n - e * 256, amp_hip, e);
      if (n >= e * 256) hip -= ramp_term(n - e * 256, amp_hip, g - e);
      knee = window_tri(n, e, f, g, longint'(cfg_amp_knee));
      third = 0;
      if (cfg_gravity) begin
         near_tri = window_tri(n, e - SHIFT_NEAR, f - SHIFT_NEAR, g - SHIFT_NEAR, CORR_AMP);
         far_tri  = window_tri(n, e - SHIFT_FAR, f - SHIFT_FAR, g - SHIFT_FAR, CORR_AMP);
         // Front-left and rear-right legs lean the opposite way to the others.
         if (leg == 0 || leg == 3) begin
            hip += near_tri - far_tri;
         end else begin
            hip += far_tri - near_tri;
         end
         knee  -= window_tri(n, b, c, d, CORR_AMP);
         third += window_tri(n, b, c, d, longint'(cfg_amp_third));
      end
      r.leg   = leg;
      r.hip   = clamp_angle(hip);
      r.knee  = clamp_angle(knee);
      r.third = clamp_angle(third);
      return r;
   endfunction

   // Applies one accepted request word to the gait model.
   task automatic apply_cmd(input logic op, input logic [LEG_W-1:0] leg,
                            input logic [PHASE_IN_W-1:0] value);
      if (leg >= LEGS) return;
      if (op == OP_LOAD) begin
         gait_phase[leg] = {1'b0, value};
         loads_seen++;
      end else begin
         if (gait_phase[leg] >= FULL_CYCLE) gait_phase[leg] = '0;
         gait_phase[leg] = gait_phase[leg] + {1'b0, cfg_inc};
         expected_angles.push_back(predict_angles(leg, longint'(gait_phase[leg])));
         advances_seen++;
      end
   endtask

   task automatic report_mismatch(input string what, input longint want, input longint got);
      error_count++;
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   task automatic push_cmd(input logic op, input logic [LEG_W-1:0] leg,
                           input logic [PHASE_IN_W-1:0] value);
      gait_cmd_type cmd;
      cmd.op    = op;
      cmd.leg   = leg;
      cmd.phase = value;
      pending_cmds.push_back(cmd);
   endtask

   // Leaves the register write valid high; the caller lowers it afterwards.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PHASE_INC:  cfg_inc       = value[INC_W-1:0];
         CSR_AMP_ALPHA:  cfg_amp_hip   = value[AMP_W-1:0];
         CSR_AMP_BETA:   cfg_amp_knee  = value[AMP_W-1:0];
         CSR_AMP_GAMMA:  cfg_amp_third = value[AMP_W-1:0];
         CSR_GRAVITY:    cfg_gravity   = value[0];
         CSR_STANCE_BRK: cfg_stance    = value[BRKS_W-1:0];
         CSR_CORR_BRK:   cfg_corr      = value[BRKS_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_all_regs(input logic [INC_W-1:0] inc, input logic [AMP_W-1:0] amp_h,
                               input logic [AMP_W-1:0] amp_k, input logic [AMP_W-1:0] amp_t,
                               input logic grav, input logic [BRKS_W-1:0] stance,
                               input logic [BRKS_W-1:0] corr);
      write_csr(CSR_PHASE_INC, CSR_DATA_W'(inc));
      write_csr(CSR_AMP_ALPHA, CSR_DATA_W'(amp_h));
      write_csr(CSR_AMP_BETA, CSR_DATA_W'(amp_k));
      write_csr(CSR_AMP_GAMMA, CSR_DATA_W'(amp_t));
      write_csr(CSR_GRAVITY, CSR_DATA_W'(grav));
      write_csr(CSR_STANCE_BRK, stance);
      write_csr(CSR_CORR_BRK, corr);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Waits until every word is sent and every angle word has come back,
   // then gives the block time to finish any trailing work.
   task automatic drain_all();
      while (pending_cmds.size() != 0 || expected_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [AMP_W-1:0] pick_amp();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return AMP_W'(180);
      return AMP_W'($urandom_range(0, 180));
   endfunction

   function automatic logic [INC_W-1:0] pick_inc();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return INC_W'(1);
      if (r == 1) return INC_W'(FULL_CYCLE);
      if (r < 5) return INC_W'($urandom_range(16, 2048));
      return INC_W'($urandom_range(1, FULL_CYCLE));
   endfunction

   // Mostly ordered breakpoints; some equal, reversed or fully random.
   function automatic logic [BRKS_W-1:0] pick_breaks();
      int lo, mid, hi, mode;
      mode = $urandom_range(0, 9);
      lo   = $urandom_range(0, 100);
      mid  = $urandom_range(lo, 127);
      hi   = $urandom_range(mid, 127);
      if (mode == 7) return BRKS_W'($urandom_range(0, (1 << BRKS_W) - 1));
      if (mode == 8) mid = lo;
      if (mode == 9) return {7'(lo), 7'(hi), 7'(mid)};
      return {7'(hi), 7'(mid), 7'(lo)};
   endfunction

   function automatic logic [PHASE_IN_W-1:0] pick_phase_value();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return PHASE_IN_W'($urandom_range(0, FULL_CYCLE - 1));
      if (r < 16) return PHASE_IN_W'($urandom_range(FULL_CYCLE, PHASE_IN_MAX));
      if (r == 16) return '0;
      if (r == 17) return PHASE_IN_W'(FULL_CYCLE - 1);
      if (r == 18) return PHASE_IN_W'(FULL_CYCLE);
      return PHASE_IN_W'(PHASE_IN_MAX);
   endfunction

   // Request driver: offers queued words, in bursts with random gaps when bursty.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            void'(pending_cmds.pop_front());
            if (sender_bursty) begin
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  gap_left   = $urandom_range(1, 20);
                  burst_left = $urandom_range(1, 12);
               end
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_cmds[0].op;
            req_tdata  <= {{(REQ_DATA_W - REQ_FIELDS_W){1'b0}},
                           pending_cmds[0].phase, pending_cmds[0].leg};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver: alternating ready and stall runs (always ready when stall_max is zero), plus one long hold.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_max == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         if (ready_run_left == 0) begin
            ready_level    = !ready_level;
            ready_run_left = ready_level ? $urandom_range(1, 16) : $urandom_range(1, stall_max);
         end
         ready_run_left--;
         rsp_tready <= ready_level;
      end
   end

   // Accepted request words update the gait model.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         apply_cmd(req_tuser, req_tdata[0 +: LEG_W], req_tdata[LEG_W +: PHASE_IN_W]);
         req_taken = 1'b1;
      end
   end

   // Each accepted angle word is checked against the oldest prediction.
   always @(posedge clock) begin : angle_check
      angle_set_type              want;
      logic [LEG_W-1:0]           got_leg;
      logic signed [ANGLE_W-1:0]  got_hip;
      logic signed [ANGLE_W-1:0]  got_knee;
      logic signed [ANGLE_W-1:0]  got_third;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_leg   = rsp_tdata[0 +: LEG_W];
         got_hip   = rsp_tdata[LEG_W +: ANGLE_W];
         got_knee  = rsp_tdata[LEG_W + ANGLE_W +: ANGLE_W];
         got_third = rsp_tdata[LEG_W + 2 * ANGLE_W +: ANGLE_W];
         angles_seen++;
         if (expected_angles.size() == 0) begin
            report_mismatch("angle word with no advance outstanding, leg", -1, got_leg);
         end else begin
            want = expected_angles.pop_front();
            if (got_leg !== want.leg) report_mismatch("leg_out", want.leg, got_leg);
            if (got_hip !== want.hip) begin
               report_mismatch("hip_angle", $signed(want.hip), got_hip);
            end
            if (got_knee !== want.knee) begin
               report_mismatch("knee_angle", $signed(want.knee), got_knee);
            end
            if (got_third !== want.third) begin
               report_mismatch("third_angle", $signed(want.third), got_third);
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d angle words outstanding",
                  cycle_count, expected_angles.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int r;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A write to an unmapped index must leave the reset values in place.
      write_csr(CSR_UNMAPPED, '1);
      @(negedge clock);
      csr_valid <= 1'b0;

      // Reset values, the wrap at full cycle and a load above the cycle range.
      for (int l = 0; l < LEGS; l++) push_cmd(OP_ADVANCE, LEG_W'(l), '0);
      push_cmd(OP_LOAD, 1, PHASE_IN_W'(FULL_CYCLE - 1));
      push_cmd(OP_ADVANCE, 1, '0);
      push_cmd(OP_LOAD, 2, PHASE_IN_W'(PHASE_IN_MAX));
      push_cmd(OP_ADVANCE, 2, PHASE_IN_W'(PHASE_IN_MAX));
      drain_all();

      // Full amplitudes with gravity correction, phases at the breakpoints.
      set_all_regs(INC_W'(1), AMP_W'(180), AMP_W'(180), AMP_W'(180), 1'b1,
                   STANCE_BRK_RESET, CORR_BRK_RESET);
      push_cmd(OP_LOAD, 0, 15'd12799);
      push_cmd(OP_ADVANCE, 0, '0);
      push_cmd(OP_LOAD, 1, 15'd19199);
      push_cmd(OP_ADVANCE, 1, '0);
      push_cmd(OP_LOAD, 2, 15'd6399);
      push_cmd(OP_ADVANCE, 2, '0);
      push_cmd(OP_LOAD, 3, PHASE_IN_W'(FULL_CYCLE - 1));
      push_cmd(OP_ADVANCE, 3, '0);
      drain_all();

      // Zero increment, a zero stance span and reversed breakpoints.
      set_all_regs('0, AMP_W'(180), AMP_W'(180), AMP_W'(180), 1'b1,
                   {7'd20, 7'd60, 7'd60}, {7'd127, 7'd30, 7'd90});
      push_cmd(OP_LOAD, 0, 15'd30000);
      push_cmd(OP_ADVANCE, 0, '0);
      push_cmd(OP_LOAD, 1, 15'd15000);
      push_cmd(OP_ADVANCE, 1, '0);
      push_cmd(OP_ADVANCE, 1, '0);
      drain_all();

      // Random settings, each followed by a mostly-advance item mix.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         sender_bursty = (p % 3 != 0);
         stall_max     = (p % 4 == 1) ? 0 : $urandom_range(1, 12);
         set_all_regs(pick_inc(), pick_amp(), pick_amp(), pick_amp(),
                      ($urandom_range(0, 9) < 7), pick_breaks(), pick_breaks());
         // One phase makes the receiver hold off while words keep coming.
         if (p == 2) begin
            sender_bursty = 1'b0;
            hold_request  = 1'b1;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 82) begin
               push_cmd(OP_ADVANCE, LEG_W'($urandom_range(0, LEGS - 1)),
                        PHASE_IN_W'($urandom_range(0, PHASE_IN_MAX)));
            end else begin
               push_cmd(OP_LOAD, LEG_W'($urandom_range(0, LEGS - 1)), pick_phase_value());
            end
         end
         drain_all();
      end

      $display("Checked %0d angle words from %0d advances and %0d phase loads.",
               angles_seen, advances_seen, loads_seen);
      $display("Used %0d register settings over %0d writes, one to an unmapped index.",
               settings_used, csr_writes);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
